// ===== design/first_fit_block_allocator_defines.svh =====
// assertion macros for the first-fit block allocator
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define FFBA_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("ffba assertion failed");

// next-cycle implication, disabled during reset
`define FFBA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("ffba assertion failed");

`else

`define FFBA_ASSERT_IMPL(label, clk, rst_n, lhs, rhs)
`define FFBA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

// ===== design/ffba_pkg.sv =====
// shared types and constants for the first-fit block allocator
package ffba_pkg;

    // defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 32;

    // fixed field widths
    localparam int CFG_W      = 5;
    localparam int LOAD_IDX_W = 4;
    localparam int FIELD_SZ_W = 32;

    // request modes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load_we;
        logic advance;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic hit;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== design/ffba_if.sv =====
// request and result channel interfaces
interface ffba_req_if
    import ffba_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [LOAD_IDX_W-1:0] load_index;
    logic [FIELD_SZ_W-1:0] load_size;
    logic [FIELD_SZ_W-1:0] request_size;

    modport source (output valid, mode, load_index, load_size, request_size, input ready);
    modport sink (input valid, mode, load_index, load_size, request_size, output ready);
endinterface

interface ffba_rsp_if
    import ffba_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  granted;
    logic [LOAD_IDX_W-1:0] granted_index;
    logic [FIELD_SZ_W-1:0] granted_size;

    modport source (output valid, granted, granted_index, granted_size, input ready);
    modport sink (input valid, granted, granted_index, granted_size, output ready);
endinterface

// ===== design/ffba_ctrl.sv =====
// controller state machine for the first-fit block allocator
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_mode,
    input  dp_status_t st,
    output logic       in_ready,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.load_we = 1'b0;
        cmd.advance = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_mode == MODE_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (st.hit || st.last)
                begin
                    // finish only when the result slot can take it
                    if (st.out_free)
                    begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ffba_datapath.sv =====
// block table, scan datapath and result register
`include "first_fit_block_allocator_defines.svh"

module ffba_datapath
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            st,
    input  logic [LOAD_IDX_W-1:0] load_index,
    input  logic [FIELD_SZ_W-1:0] load_size,
    input  logic [FIELD_SZ_W-1:0] request_size,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  granted,
    output logic [LOAD_IDX_W-1:0] granted_index,
    output logic [FIELD_SZ_W-1:0] granted_size
);

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int LIW   = (IDX_W > LOAD_IDX_W) ? IDX_W : LOAD_IDX_W;

    logic [CFG_W-1:0]      blocks_in_use_reg;
    logic [CNT_W-1:0]      limit_reg;
    logic [CNT_W-1:0]      limit_next;
    logic [SIZE_BITS-1:0]  req_size_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SIZE_BITS-1:0]  rdata_reg;
    logic [SIZE_BITS-1:0]  mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] taken_reg;
    logic                  out_valid_reg;
    logic                  granted_reg;
    logic [LOAD_IDX_W-1:0] granted_index_reg;
    logic [FIELD_SZ_W-1:0] granted_size_reg;

    logic [CMP_W-1:0]      cfg_ext;
    logic [CMP_W-1:0]      max_ext;
    logic [CNT_W-1:0]      idx_plus;
    logic [IDX_W-1:0]      rd_addr;
    logic [LIW-1:0]        lidx_ext;
    logic [IDX_W-1:0]      wr_addr;
    logic                  load_ok;
    logic                  mem_we;

    // participating block count, clamped to the table depth
    assign cfg_ext    = CMP_W'(blocks_in_use_reg);
    assign max_ext    = CMP_W'(MAX_BLOCKS);
    assign limit_next = CNT_W'((cfg_ext > max_ext) ? max_ext : cfg_ext);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            blocks_in_use_reg <= cfg_wdata;
        end
    end

    // load address decode, out-of-table loads dropped
    assign lidx_ext = LIW'(load_index);
    assign wr_addr  = lidx_ext[IDX_W-1:0];
    assign load_ok  = 32'(load_index) < 32'(MAX_BLOCKS);
    assign mem_we   = cmd.load_we && load_ok;

    // scan address: block 0 on capture, next block on advance
    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);
    always_comb
    begin
        if (cmd.capture)
        begin
            rd_addr = '0;
        end
        else if (cmd.advance)
        begin
            rd_addr = IDX_W'(idx_plus);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    // size table with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= SIZE_BITS'(load_size);
        end
        rdata_reg <= mem[rd_addr];
    end

    // request capture and scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.capture)
        begin
            idx_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= IDX_W'(idx_plus);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_size_reg <= SIZE_BITS'(request_size);
            limit_reg    <= limit_next;
        end
    end

    // fit test on the block now read out
    assign st.hit      = (limit_reg != '0) && !taken_reg[idx_reg] && (req_size_reg <= rdata_reg);
    assign st.last     = (limit_reg == '0) || (idx_plus == limit_reg);
    assign st.out_free = !out_valid_reg || out_ready;

    // taken flags: load clears, grant sets
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= '0;
        end
        else if (mem_we)
        begin
            taken_reg[wr_addr] <= 1'b0;
        end
        else if (cmd.commit && st.hit)
        begin
            taken_reg[idx_reg] <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            granted_reg       <= st.hit;
            granted_index_reg <= st.hit ? LOAD_IDX_W'(idx_reg) : '0;
            granted_size_reg  <= st.hit ? FIELD_SZ_W'(rdata_reg) : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign granted_index = granted_index_reg;
    assign granted_size  = granted_size_reg;

    // checks
    `FFBA_ASSERT_IMPL(a_commit_slot_free, clk, rst_n, cmd.commit, !out_valid_reg || out_ready)
    `FFBA_ASSERT_NEXT(a_grant_marks_taken, clk, rst_n, cmd.commit && st.hit, taken_reg[$past(idx_reg)])
    `FFBA_ASSERT_IMPL(a_miss_fields_zero, clk, rst_n, out_valid_reg && !granted_reg, (granted_index_reg == '0) && (granted_size_reg == '0))

endmodule

// ===== design/first_fit_block_allocator.sv =====
// top level of the first-fit block allocator
//
//  channel  dir  handshake        payload
//  req      in   valid / ready    mode, load_index, load_size, request_size
//  rsp      out  valid / ready    granted, granted_index, granted_size
//  cfg      in   cfg_we           cfg_wdata = blocks_in_use
//
// a load gives no result
// a request scans the table one block at a time, set by
// the single registered read port of the size table
// reset clears the taken flags and the block count at once; no clearing pass
// a result waiting on rsp.ready holds the scan at its last block until taken
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = SIZE_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ffba_req_if.sink         req,
    ffba_rsp_if.source       rsp
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    // controller
    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .st       (st),
        .in_ready (req.ready),
        .cmd      (cmd)
    );

    // datapath
    ffba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .st            (st),
        .load_index    (req.load_index),
        .load_size     (req.load_size),
        .request_size  (req.request_size),
        .out_ready     (rsp.ready),
        .out_valid     (rsp.valid),
        .granted       (rsp.granted),
        .granted_index (rsp.granted_index),
        .granted_size  (rsp.granted_size)
    );

endmodule
